/* sv/quantized_neuron_mac_requant_relu_core_assert.svh */
// Assertion macros used by the port-level checker of the neuron core.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef QUANTIZED_NEURON_MAC_REQUANT_RELU_CORE_ASSERT_SVH
`define QUANTIZED_NEURON_MAC_REQUANT_RELU_CORE_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define QNMRR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define QNMRR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/qnmrr_pkg.sv */
// Package for the quantized neuron MAC / requantize / ReLU core.
// Holds widths, register indexes, reset values and the sequencer state type.
// Depends on nothing.
`default_nettype none

package qnmrr_pkg;

  // Number of output neurons; the result index wraps at this count.
  localparam int MAX_NEURONS = 1024;

  // Stream word widths.
  localparam int S_TDATA_W = 96;
  localparam int M_TDATA_W = 24;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IN_ZERO_POINT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_ZERO_POINT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_BITS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_MODE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIX_LEVEL      = 3'd4;

  // Register reset values.
  localparam logic signed [7:0] IN_ZERO_POINT_RST  = 8'sd0;
  localparam logic signed [7:0] OUT_ZERO_POINT_RST = 8'sd0;
  localparam logic [3:0]        VALUE_BITS_RST     = 4'd8;
  localparam logic              CLIP_MODE_RST      = 1'b0;
  localparam logic signed [7:0] SIX_LEVEL_RST      = 8'sd127;

  // Clip modes.
  localparam logic CLIP_RELU  = 1'b0;
  localparam logic CLIP_RELU6 = 1'b1;

  // Saturation width limits.
  localparam logic [3:0] VALUE_BITS_MIN = 4'd2;
  localparam logic [3:0] VALUE_BITS_MAX = 4'd8;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MAC  = 8'b0000_0010,
    ST_ACC  = 8'b0000_0100,
    ST_ABS  = 8'b0000_1000,
    ST_MUL  = 8'b0001_0000,
    ST_RND  = 8'b0010_0000,
    ST_SHF  = 8'b0100_0000,
    ST_SAT  = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

/* sv/quantized_neuron_mac_requant_relu_core.sv */
// Quantized dense-layer neuron: multiply-accumulate, requantize, ReLU / ReLU6.
// Top level of the block; depends on qnmrr_pkg.
//
// Usage: one input word carries an activation/weight pair plus the neuron's bias,
// scale and index. The first word of a neuron (tuser high) loads the bias into
// the 32-bit wrapping accumulator; every word adds (activation - in_zero_point)
// times weight. The word with tlast high closes the neuron and yields one output
// word with the clipped 8-bit activation and the neuron index.
// Timing: a word is taken in ST_IDLE only. A word without tlast occupies the
// block for accept, multiply and accumulate (ST_IDLE, ST_MAC, ST_ACC); a word
// with tlast goes on through ST_ABS, ST_MUL, ST_RND, ST_SHF and ST_SAT, and its
// output word is registered when ST_SAT hands it over. One 33 x 32 multiplier
// is shared by the product term and the requantization multiply, and the
// sequencer steps it through absolute value, multiply, rounding add and right shift.
// Stall: a finished output word waits in the output register while new input
// words are still taken; only a second result waits in the clamp step until
// the receiver takes the first.
// Reset (rst, synchronous) clears the accumulator, the configuration registers
// to their defaults, the sequencer and the output valid flag.
`default_nettype none

module quantized_neuron_mac_requant_relu_core (
  input  wire                                  clk,
  input  wire                                  rst,
  // Configuration write port.
  input  wire                                  cfg_wr_en,
  input  wire [qnmrr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [qnmrr_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Input stream.
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  // s_tdata, low bit up: activation[7:0], weight[15:8], bias_value[47:16],
  // scale_mult[78:48], scale_shift[84:79], neuron_index[94:85], zero pad[95].
  input  wire [qnmrr_pkg::S_TDATA_W-1:0]       s_tdata,
  // s_tuser: first_elem[0].
  input  wire                                  s_tuser,
  input  wire                                  s_tlast,
  // Output stream.
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  // m_tdata, low bit up: out_value[7:0], out_index[17:8], zero pad[23:18].
  output logic [qnmrr_pkg::M_TDATA_W-1:0]      m_tdata
);

  import qnmrr_pkg::*;

  // Configuration registers.
  logic signed [7:0] in_zero_point;
  logic signed [7:0] out_zero_point;
  logic [3:0]        value_bits;
  logic              clip_mode;
  logic signed [7:0] six_level;

  // Captured input word.
  logic signed [7:0] activation;
  logic signed [7:0] weight;
  logic              first_elem;
  logic              last_elem;
  logic [31:0]       bias_value;
  logic [30:0]       scale_mult;
  logic signed [5:0] scale_shift;
  logic [9:0]        neuron_index;

  // Datapath registers.
  state_t            state;
  state_t            state_next;
  logic [31:0]       accumulator;
  logic [31:0]       mag;
  logic              neg;
  logic [5:0]        rshift;
  logic [61:0]       mul_res;
  logic [62:0]       work;

  // Output register.
  logic signed [7:0] out_value;
  logic [9:0]        out_index;

  // Shared multiplier operands and result.
  logic signed [8:0]  mac_diff;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] mul_p;

  // Requantization helpers.
  logic signed [6:0]  rshift_full;
  logic [62:0]        round_add;
  logic               out_load;

  // Saturation and clipping.
  logic [3:0]         vb;
  logic signed [9:0]  hi_lim;
  logic signed [9:0]  lo_lim;
  logic signed [9:0]  small_val;
  logic signed [9:0]  val_sum;
  logic signed [9:0]  val_sat;
  logic signed [9:0]  val_relu;
  logic signed [9:0]  val_clip;

  assign s_tready = (state == ST_IDLE);

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_zero_point  <= IN_ZERO_POINT_RST;
      out_zero_point <= OUT_ZERO_POINT_RST;
      value_bits     <= VALUE_BITS_RST;
      clip_mode      <= CLIP_MODE_RST;
      six_level      <= SIX_LEVEL_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IN_ZERO_POINT:  in_zero_point  <= $signed(cfg_data[7:0]);
        CFG_OUT_ZERO_POINT: out_zero_point <= $signed(cfg_data[7:0]);
        CFG_VALUE_BITS:     value_bits     <= cfg_data[3:0];
        CFG_CLIP_MODE:      clip_mode      <= cfg_data[0];
        CFG_SIX_LEVEL:      six_level      <= $signed(cfg_data[7:0]);
        default: ;
      endcase
    end
  end

  // Capture the input word when it is accepted.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      activation   <= $signed(s_tdata[7:0]);
      weight       <= $signed(s_tdata[15:8]);
      bias_value   <= s_tdata[47:16];
      scale_mult   <= s_tdata[78:48];
      scale_shift  <= $signed(s_tdata[84:79]);
      neuron_index <= s_tdata[94:85];
      first_elem   <= s_tuser;
      last_elem    <= s_tlast;
    end
  end

  // Shared multiplier: product term in ST_MAC, magnitude times scale in ST_MUL.
  assign mac_diff = 9'(activation) - 9'(in_zero_point);

  always_comb begin
    if (state == ST_MUL) begin
      mul_a = $signed({1'b0, mag});
      mul_b = $signed({1'b0, scale_mult});
    end else begin
      mul_a = 33'(mac_diff);
      mul_b = 32'(weight);
    end
  end

  assign mul_p = 65'(mul_a) * 65'(mul_b);

  // Right shift amount is 31 - scale_shift, always 0..63.
  assign rshift_full = 7'sd31 - 7'(scale_shift);

  // Half of the last kept unit, none when nothing is shifted out.
  assign round_add = (rshift == 6'd0) ? 63'd0 : (63'd1 << (rshift - 6'd1));

  // Clamp the saturation width to its legal span.
  always_comb begin
    if (value_bits < VALUE_BITS_MIN) begin
      vb = VALUE_BITS_MIN;
    end else if (value_bits > VALUE_BITS_MAX) begin
      vb = VALUE_BITS_MAX;
    end else begin
      vb = value_bits;
    end
  end

  assign hi_lim = (10'sd1 <<< (vb - 4'd1)) - 10'sd1;
  assign lo_lim = -hi_lim - 10'sd1;

  // Signed requantized value when it fits in eight magnitude bits.
  assign small_val = neg ? -$signed({2'b00, work[7:0]}) : $signed({2'b00, work[7:0]});
  assign val_sum   = small_val + 10'(out_zero_point);

  // Saturate, then ReLU at the zero point, then the optional upper clip.
  always_comb begin
    if (|work[62:8]) begin
      val_sat = neg ? lo_lim : hi_lim;
    end else if (val_sum > hi_lim) begin
      val_sat = hi_lim;
    end else if (val_sum < lo_lim) begin
      val_sat = lo_lim;
    end else begin
      val_sat = val_sum;
    end

    if (val_sat < 10'(out_zero_point)) begin
      val_relu = 10'(out_zero_point);
    end else begin
      val_relu = val_sat;
    end

    if (clip_mode == CLIP_RELU6 && val_relu > 10'(six_level)) begin
      val_clip = 10'(six_level);
    end else begin
      val_clip = val_relu;
    end
  end

  // The clamp step hands over its result once the output register is free.
  assign out_load = (state == ST_SAT) && (!m_tvalid || m_tready);

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_MAC;
      ST_MAC:  state_next = ST_ACC;
      ST_ACC:  state_next = last_elem ? ST_ABS : ST_IDLE;
      ST_ABS:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_RND;
      ST_RND:  state_next = ST_SHF;
      ST_SHF:  state_next = ST_SAT;
      ST_SAT:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Accumulator: bias load on the first element, wrapping add of the product.
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= 32'd0;
    end else if (state == ST_ACC) begin
      accumulator <= (first_elem ? bias_value : accumulator) + mul_res[31:0];
    end
  end

  // Requantization datapath: sign/magnitude, multiply, round, shift.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_ABS: begin
        neg    <= accumulator[31];
        mag    <= accumulator[31] ? (~accumulator + 32'd1) : accumulator;
        rshift <= rshift_full[5:0];
      end
      ST_RND:  work <= {1'b0, mul_res} + round_add;
      ST_SHF:  work <= work >> rshift;
      default: ;
    endcase
    if (state == ST_MAC || state == ST_MUL) begin
      mul_res <= mul_p[61:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= val_clip[7:0];
      out_index <= 10'(32'(neuron_index) % MAX_NEURONS);
    end
  end

  assign m_tdata = {6'd0, out_index, out_value};

endmodule

`default_nettype wire

/* sv/qnmrr_chk.sv */
// Port-level checker for the neuron core, bound to its top level.
// Depends on qnmrr_pkg and the assertion macro header.
`default_nettype none
`include "quantized_neuron_mac_requant_relu_core_assert.svh"

module qnmrr_chk (
  input wire                                  clk,
  input wire                                  rst,
  input wire                                  s_tvalid,
  input wire                                  s_tready,
  input wire                                  s_tlast,
  input wire                                  m_tvalid,
  input wire                                  m_tready,
  input wire [qnmrr_pkg::M_TDATA_W-1:0]       m_tdata
);

  // A stalled output word stays valid and unchanged.
  `QNMRR_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")

  // Reset leaves no output word pending.
  `QNMRR_ASSERT_NEXT(a_rst_empty, clk, 1'b0, rst, !m_tvalid, "output valid after reset")

  // Each accepted word keeps the block busy for at least the multiply step.
  `QNMRR_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "input taken on consecutive cycles")

  // A word that does not close a neuron never produces an output word.
  `QNMRR_ASSERT_NEXT(a_no_spurious_out, clk, rst, s_tvalid && s_tready && !s_tlast && !m_tvalid, !m_tvalid, "output word without a closing input word")

endmodule

bind quantized_neuron_mac_requant_relu_core qnmrr_chk u_qnmrr_chk (.*);

`default_nettype wire
